[sv/spi_rac_pkg.sv]
// ----------------------------------------------------------------------------
// spi_rac_pkg
// Shared opcodes, narrow register list and result type for the SPI
// register access slave.
// ----------------------------------------------------------------------------
package spi_rac_pkg;

  localparam logic [7:0] OP_SETADDR  = 8'h20;
  localparam logic [7:0] OP_WRITEREG = 8'h2D;
  localparam logic [7:0] OP_READREG  = 8'h6D;
  localparam logic [7:0] READ_STATUS = 8'h80;

  localparam int unsigned NumNarrow = 8;

  // registers that are accessed as 16 bits, all others are 32 bits
  localparam logic [15:0] NARROW_REGS [NumNarrow] = '{
    16'h0400, 16'h0404, 16'h0410, 16'h21F0,
    16'h0A28, 16'h0908, 16'h0C08, 16'h22F0
  };

  typedef struct packed {
    logic [7:0]  miso_value;
    logic        write_strobe;
    logic [15:0] reg_address;
    logic [31:0] write_data;
    logic        read_strobe;
    logic        wide_access;
    logic        ignored_flag;
  } result_t;

  function automatic logic is_wide(input logic [15:0] addr);
    logic wide;
    wide = 1'b1;
    for (int i = 0; i < NumNarrow; i++) begin
      if (NARROW_REGS[i] == addr) wide = 1'b0;
    end
    return wide;
  endfunction

endpackage

[sv/spi_register_access_slave_core.sv]
// path: a transaction is captured in the input register, then moves through the decode
//   stage into the result register once that slot is free or being emptied
// throughput: one byte per cycle while out_ready_i does not stall the result, set by the
//   input register feeding the decode stage and the result register behind it; both advance together
// reset: rst_ni clears both stage valids, the command state (idle, no frame),
//   the address and the shift/latch registers
// ----------------------------------------------------------------------------
// spi_register_access_slave_core
// Device-side SPI command front end: opcode decode, address load, register
// write assembly and read data return, one MISO byte per MOSI byte.
// ----------------------------------------------------------------------------
module spi_register_access_slave_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input channel
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        frame_start_i,
  input  logic [7:0]  mosi_value_i,
  input  logic [31:0] read_value_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  miso_value_o,
  output logic        write_strobe_o,
  output logic [15:0] reg_address_o,
  output logic [31:0] write_data_o,
  output logic        read_strobe_o,
  output logic        wide_access_o,
  output logic        ignored_flag_o
);

  // input register stage
  logic        in_vld_q, in_vld_d;
  logic        fs_q;
  logic [7:0]  mosi_q;
  logic [31:0] rv_q;

  // result register stage
  logic                 out_vld_q, out_vld_d;
  spi_rac_pkg::result_t res_q;
  spi_rac_pkg::result_t res_comb;

  logic in_fire;
  logic advance;

  // the decode stage moves when it holds a byte and the result slot is free
  // or being emptied in this cycle
  assign advance    = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || advance;
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    in_vld_d = in_vld_q;
    if (in_fire) begin
      in_vld_d = 1'b1;
    end else if (advance) begin
      in_vld_d = 1'b0;
    end

    out_vld_d = out_vld_q;
    if (advance) begin
      out_vld_d = 1'b1;
    end else if (out_ready_i) begin
      out_vld_d = 1'b0;
    end
  end

  // command state is stepped exactly once per transaction, when it moves on
  spi_rac_decode u_decode (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (advance),
    .frame_start_i (fs_q),
    .mosi_value_i  (mosi_q),
    .read_value_i  (rv_q),
    .result_o      (res_comb)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      fs_q   <= frame_start_i;
      mosi_q <= mosi_value_i;
      rv_q   <= read_value_i;
    end
    if (advance) begin
      res_q <= res_comb;
    end
  end

  assign out_valid_o    = out_vld_q;
  assign miso_value_o   = res_q.miso_value;
  assign write_strobe_o = res_q.write_strobe;
  assign reg_address_o  = res_q.reg_address;
  assign write_data_o   = res_q.write_data;
  assign read_strobe_o  = res_q.read_strobe;
  assign wide_access_o  = res_q.wide_access;
  assign ignored_flag_o = res_q.ignored_flag;

endmodule

[sv/spi_rac_decode.sv]
// ----------------------------------------------------------------------------
// spi_rac_decode
// Command state and per-byte decode; state advances on each stepped byte.
// ----------------------------------------------------------------------------
module spi_rac_decode (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   step_i,
  input  logic                   frame_start_i,
  input  logic [7:0]             mosi_value_i,
  input  logic [31:0]            read_value_i,
  output spi_rac_pkg::result_t   result_o
);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_ADDR,
    PH_WRITE,
    PH_READ,
    PH_DONE
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [2:0]  pos_q, pos_d;
  logic [15:0] addr_q, addr_d;
  logic [7:0]  ashift_q, ashift_d;
  logic [31:0] dshift_q, dshift_d;
  logic [31:0] rlatch_q, rlatch_d;

  logic        wide_cur;
  logic [2:0]  nbytes;
  logic [2:0]  pos_inc;
  logic [31:0] dshift_next;
  logic [2:0]  byte_sel;

  always_comb begin
    wide_cur    = spi_rac_pkg::is_wide(addr_q);
    nbytes      = wide_cur ? 3'd4 : 3'd2;
    pos_inc     = pos_q + 3'd1;
    dshift_next = {dshift_q[23:0], mosi_value_i};
    byte_sel    = nbytes - pos_q;

    phase_d  = phase_q;
    pos_d    = pos_q;
    addr_d   = addr_q;
    ashift_d = ashift_q;
    dshift_d = dshift_q;
    rlatch_d = rlatch_q;

    result_o = '0;

    if (frame_start_i) begin
      pos_d = 3'd0;
      unique case (mosi_value_i)
        spi_rac_pkg::OP_SETADDR: begin
          phase_d = PH_ADDR;
        end
        spi_rac_pkg::OP_WRITEREG: begin
          phase_d  = PH_WRITE;
          dshift_d = '0;
        end
        spi_rac_pkg::OP_READREG: begin
          phase_d              = PH_READ;
          rlatch_d             = read_value_i;
          result_o.read_strobe = 1'b1;
        end
        default: begin
          phase_d               = PH_DONE;
          result_o.ignored_flag = 1'b1;
        end
      endcase
    end else begin
      unique case (phase_q)
        PH_ADDR: begin
          if (pos_q == 3'd0) begin
            ashift_d = mosi_value_i;
            pos_d    = 3'd1;
          end else begin
            addr_d  = {ashift_q, mosi_value_i};
            phase_d = PH_DONE;
          end
        end
        PH_WRITE: begin
          dshift_d = dshift_next;
          pos_d    = pos_inc;
          if (pos_inc >= nbytes) begin
            result_o.write_strobe = 1'b1;
            result_o.write_data   = wide_cur ? dshift_next : {16'h0, dshift_next[15:0]};
            phase_d               = PH_DONE;
          end
        end
        PH_READ: begin
          if (pos_q == 3'd0) begin
            result_o.miso_value = spi_rac_pkg::READ_STATUS;
          end else begin
            result_o.miso_value = rlatch_q[{byte_sel[1:0], 3'b000} +: 8];
          end
          pos_d = pos_inc;
          if (pos_inc > nbytes) phase_d = PH_DONE;
        end
        default: begin
          result_o.ignored_flag = 1'b1;
        end
      endcase
    end

    result_o.reg_address = addr_d;
    result_o.wide_access = spi_rac_pkg::is_wide(addr_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      pos_q    <= '0;
      addr_q   <= '0;
      ashift_q <= '0;
      dshift_q <= '0;
      rlatch_q <= '0;
    end else if (step_i) begin
      phase_q  <= phase_d;
      pos_q    <= pos_d;
      addr_q   <= addr_d;
      ashift_q <= ashift_d;
      dshift_q <= dshift_d;
      rlatch_q <= rlatch_d;
    end
  end

endmodule

[sv/spi_rac_checker.sv]
// ----------------------------------------------------------------------------
// spi_rac_checker
// Port-level checks on the result channel of the SPI register access slave.
// ----------------------------------------------------------------------------
module spi_rac_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [7:0]  miso_value_o,
  input logic        write_strobe_o,
  input logic [15:0] reg_address_o,
  input logic [31:0] write_data_o,
  input logic        read_strobe_o,
  input logic        wide_access_o,
  input logic        ignored_flag_o
);

  // a stalled transaction keeps its result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(miso_value_o)
      && $stable(write_data_o) && $stable(reg_address_o))
    else $error("result changed while stalled");

  // at most one strobe per transaction
  a_one_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(write_strobe_o && read_strobe_o))
    else $error("write and read strobe together");

  // ignored bytes and read opcode slots return zero on miso
  a_miso_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (ignored_flag_o || read_strobe_o) |-> miso_value_o == 8'h00)
    else $error("nonzero miso on ignored or opcode slot");

  // write data only shows with its strobe, narrow writes zero extended
  a_wdata: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (!write_strobe_o || !wide_access_o) |-> write_data_o[31:16] == 16'h0
      && (write_strobe_o || write_data_o[15:0] == 16'h0))
    else $error("write data not cleared or not zero extended");

  // the listed narrow registers 0x0400 and 0x22F0 are never reported wide
  a_narrow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (reg_address_o == 16'h0400 || reg_address_o == 16'h22F0)
      |-> !wide_access_o)
    else $error("narrow register reported wide");

endmodule

bind spi_register_access_slave_core spi_rac_checker u_spi_rac_checker (.*);
